// ===== rtl/tmvg_pkg.sv =====
`timescale 1ns / 1ps

package tmvg_pkg;

    localparam int MAX_SEGMENTS_DEF = 4096;

    localparam int IDX_W   = 12;
    localparam int CNT_W   = 13;
    localparam int RAD_W   = 16;
    localparam int POS_W   = 18;
    localparam int NUM_W   = 24;
    localparam int ANG_W   = 16;
    localparam int DIV_STEPS = ANG_W;
    localparam int SINE_W  = 17;
    localparam int X_W     = 15;
    localparam int X2_W    = 29;
    localparam int P_W     = 31;
    localparam int SINE_STAGES = 6;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 128;

    localparam logic [1:0] CFG_MAJOR_RADIUS = 2'd0;
    localparam logic [1:0] CFG_MINOR_RADIUS = 2'd1;
    localparam logic [1:0] CFG_MAJOR_COUNT  = 2'd2;
    localparam logic [1:0] CFG_MINOR_COUNT  = 2'd3;

    localparam logic [P_W-1:0] C_POLY [5] = '{
        31'd1686629713,
        31'd693598669,
        31'd85569306,
        31'd5026995,
        31'd172272
    };

endpackage

// ===== rtl/tmvg_div_cell.sv =====
`timescale 1ns / 1ps

module tmvg_div_cell (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [tmvg_pkg::CNT_W-1:0] i_div,
    input  logic [tmvg_pkg::CNT_W-1:0] i_rem,
    input  logic [tmvg_pkg::ANG_W-1:0] i_quo,
    output logic [tmvg_pkg::CNT_W-1:0] o_rem,
    output logic [tmvg_pkg::ANG_W-1:0] o_quo
);
    import tmvg_pkg::*;

    logic [CNT_W:0]   w_dbl;
    logic [CNT_W:0]   w_diff;
    logic             w_ge;
    logic [CNT_W-1:0] n_rem;

    assign w_dbl  = {i_rem, 1'b0};
    assign w_diff = w_dbl - {1'b0, i_div};
    assign w_ge   = (w_dbl >= {1'b0, i_div});
    assign n_rem  = w_ge ? w_diff[CNT_W-1:0] : w_dbl[CNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem <= n_rem;
            o_quo <= {i_quo[ANG_W-2:0], w_ge};
        end
    end

endmodule

// ===== rtl/tmvg_horner_cell.sv =====
`timescale 1ns / 1ps

module tmvg_horner_cell #(
    parameter int K = 0
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [tmvg_pkg::X_W-1:0]  i_x,
    input  logic [tmvg_pkg::X2_W-1:0] i_x2,
    input  logic [tmvg_pkg::P_W-1:0]  i_p,
    output logic [tmvg_pkg::X_W-1:0]  o_x,
    output logic [tmvg_pkg::X2_W-1:0] o_x2,
    output logic [tmvg_pkg::P_W-1:0]  o_p
);
    import tmvg_pkg::*;

    logic [X2_W+P_W-1:0] w_prod;
    logic [P_W:0]        w_diff;

    assign w_prod = i_x2 * i_p;
    assign w_diff = {1'b0, C_POLY[K]} - w_prod[X2_W+P_W-1:28];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x  <= i_x;
            o_x2 <= i_x2;
            o_p  <= w_diff[P_W-1:0];
        end
    end

endmodule

// ===== rtl/tmvg_qsine.sv =====
`timescale 1ns / 1ps

module tmvg_qsine (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [tmvg_pkg::X_W-1:0]    i_x,
    output logic [tmvg_pkg::SINE_W-1:0] o_p
);
    import tmvg_pkg::*;

    logic [X_W-1:0]  w_x  [0:4];
    logic [X2_W-1:0] w_x2 [0:4];
    logic [P_W-1:0]  w_p  [0:4];
    logic [2*X_W-1:0] w_sq;
    logic [X_W+P_W-1:0] w_fin;
    logic [X_W+P_W-29:0] w_sh;

    assign w_sq = i_x * i_x;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            w_x[0]  <= i_x;
            w_x2[0] <= w_sq[X2_W-1:0];
        end
    end

    assign w_p[0] = C_POLY[4];

    for (genvar k = 0; k < 4; k++) begin : g_cell
        tmvg_horner_cell #(.K(3 - k)) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_x   (w_x[k]),
            .i_x2  (w_x2[k]),
            .i_p   (w_p[k]),
            .o_x   (w_x[k+1]),
            .o_x2  (w_x2[k+1]),
            .o_p   (w_p[k+1])
        );
    end

    assign w_fin = w_x[4] * w_p[4];
    assign w_sh  = w_fin[X_W+P_W-1:28];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_p <= (w_sh > 18'd65536) ? 17'd65536 : w_sh[SINE_W-1:0];
        end
    end

endmodule

// ===== rtl/torus_mesh_vertex_generator.sv =====
`timescale 1ns / 1ps

// Takes one grid position per cycle and returns the torus vertex there together with its
// vertex number and the numbers of its two wrapping neighbours. A new request is taken in
// every cycle while the output side keeps up; each result is presented at the output once
// its request has passed through the index register, the 16-cell restoring divider chain
// that forms the angles, the six-stage polynomial sine chain and three stages of radius
// products and saturation. An index at or beyond its segment count gives all-zero data with
// the error flag in tuser set. The user must write configuration through the cfg channel
// only while no request is in flight; the block itself does not enforce this.

module torus_mesh_vertex_generator #(
    parameter int MAX_SEGMENTS = tmvg_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // major_index [11:0], minor_index [23:12]
    input  logic [tmvg_pkg::IN_DATA_W-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // pos_x, pos_y, pos_z, vertex_number, next_minor_number, next_major_number, zero pad
    output logic [tmvg_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // index_error
    output logic                            o_m_tuser,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [1:0]                      i_cfg_index,
    input  logic [tmvg_pkg::RAD_W-1:0]      i_cfg_data
);
    import tmvg_pkg::*;

    localparam int S_DIV  = DIV_STEPS;
    localparam int S_SINE = S_DIV + SINE_STAGES;
    localparam int S_RING = S_SINE + 1;
    localparam int S_MUL  = S_RING + 1;
    localparam int S_OUT  = S_MUL + 1;

    logic [RAD_W-1:0] r_major_radius;
    logic [RAD_W-1:0] r_minor_radius;
    logic [CNT_W-1:0] r_major_count;
    logic [CNT_W-1:0] r_minor_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_major_radius <= 16'd256;
            r_minor_radius <= 16'd64;
            r_major_count  <= 13'd48;
            r_minor_count  <= 13'd24;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAJOR_RADIUS: r_major_radius <= i_cfg_data;
                CFG_MINOR_RADIUS: r_minor_radius <= i_cfg_data;
                CFG_MAJOR_COUNT:  r_major_count  <= i_cfg_data[CNT_W-1:0];
                CFG_MINOR_COUNT:  r_minor_count  <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    logic [CNT_W-1:0] w_m;
    logic [CNT_W-1:0] w_n;

    assign w_m = (32'(r_major_count) > MAX_SEGMENTS) ? CNT_W'(MAX_SEGMENTS) : r_major_count;
    assign w_n = (32'(r_minor_count) > MAX_SEGMENTS) ? CNT_W'(MAX_SEGMENTS) : r_minor_count;

    logic [S_OUT:0] r_vld;
    logic           w_en;
    logic           w_acc;

    assign w_en       = !r_vld[S_OUT] || i_m_tready;
    assign o_s_tready = w_en;
    assign w_acc      = i_s_tvalid && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[S_OUT-1:0], w_acc};
        end
    end

    logic [IDX_W-1:0] w_i;
    logic [IDX_W-1:0] w_j;
    logic [CNT_W-1:0] w_i1;
    logic [CNT_W-1:0] w_j1;
    logic [IDX_W-1:0] r_i;
    logic [IDX_W-1:0] r_j;
    logic [CNT_W-1:0] r_ni;
    logic [CNT_W-1:0] r_nj;
    logic             r_err0;

    assign w_i  = i_s_tdata[IDX_W-1:0];
    assign w_j  = i_s_tdata[2*IDX_W-1:IDX_W];
    assign w_i1 = {1'b0, w_i} + 13'd1;
    assign w_j1 = {1'b0, w_j} + 13'd1;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_i    <= w_i;
            r_j    <= w_j;
            r_ni   <= (w_i1 == w_m) ? '0 : w_i1;
            r_nj   <= (w_j1 == w_n) ? '0 : w_j1;
            r_err0 <= ({1'b0, w_i} >= w_m) || ({1'b0, w_j} >= w_n);
        end
    end

    logic [2*CNT_W-1:0] w_in_prod;
    logic [2*CNT_W-1:0] w_ni_prod;
    logic             r_err [1:S_MUL];
    logic [NUM_W-1:0] r_vn  [1:S_MUL];
    logic [NUM_W-1:0] r_vnj [1:S_MUL];
    logic [NUM_W-1:0] r_vni [1:S_MUL];

    assign w_in_prod = {1'b0, r_i} * w_n;
    assign w_ni_prod = r_ni * w_n;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_err[1] <= r_err0;
            r_vn[1]  <= w_in_prod[NUM_W-1:0] + NUM_W'(r_j);
            r_vnj[1] <= w_in_prod[NUM_W-1:0] + NUM_W'(r_nj);
            r_vni[1] <= w_ni_prod[NUM_W-1:0] + NUM_W'(r_j);
            for (int k = 2; k <= S_MUL; k++) begin
                r_err[k] <= r_err[k-1];
                r_vn[k]  <= r_vn[k-1];
                r_vnj[k] <= r_vnj[k-1];
                r_vni[k] <= r_vni[k-1];
            end
        end
    end

    logic [CNT_W-1:0] w_rem_a [0:DIV_STEPS];
    logic [CNT_W-1:0] w_rem_b [0:DIV_STEPS];
    logic [ANG_W-1:0] w_quo_a [0:DIV_STEPS];
    logic [ANG_W-1:0] w_quo_b [0:DIV_STEPS];

    assign w_rem_a[0] = {1'b0, r_i};
    assign w_rem_b[0] = {1'b0, r_j};
    assign w_quo_a[0] = '0;
    assign w_quo_b[0] = '0;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        tmvg_div_cell u_div_a (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_div (w_m),
            .i_rem (w_rem_a[k]),
            .i_quo (w_quo_a[k]),
            .o_rem (w_rem_a[k+1]),
            .o_quo (w_quo_a[k+1])
        );
        tmvg_div_cell u_div_b (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_div (w_n),
            .i_rem (w_rem_b[k]),
            .i_quo (w_quo_b[k]),
            .o_rem (w_rem_b[k+1]),
            .o_quo (w_quo_b[k+1])
        );
    end

    logic [ANG_W-1:0] w_ang_a;
    logic [ANG_W-1:0] w_ang_b;
    logic [X_W-1:0]   w_fa;
    logic [X_W-1:0]   w_fb;
    logic [SINE_W-1:0] w_pfa;
    logic [SINE_W-1:0] w_pga;
    logic [SINE_W-1:0] w_pfb;
    logic [SINE_W-1:0] w_pgb;

    assign w_ang_a = w_quo_a[DIV_STEPS];
    assign w_ang_b = w_quo_b[DIV_STEPS];
    assign w_fa    = {1'b0, w_ang_a[13:0]};
    assign w_fb    = {1'b0, w_ang_b[13:0]};

    tmvg_qsine u_pfa (.i_clk(i_clk), .i_en(w_en), .i_x(w_fa), .o_p(w_pfa));
    tmvg_qsine u_pga (.i_clk(i_clk), .i_en(w_en), .i_x(15'd16384 - w_fa), .o_p(w_pga));
    tmvg_qsine u_pfb (.i_clk(i_clk), .i_en(w_en), .i_x(w_fb), .o_p(w_pfb));
    tmvg_qsine u_pgb (.i_clk(i_clk), .i_en(w_en), .i_x(15'd16384 - w_fb), .o_p(w_pgb));

    logic [1:0] r_qa [1:SINE_STAGES];
    logic [1:0] r_qb [1:SINE_STAGES];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_qa[1] <= w_ang_a[15:14];
            r_qb[1] <= w_ang_b[15:14];
            for (int k = 2; k <= SINE_STAGES; k++) begin
                r_qa[k] <= r_qa[k-1];
                r_qb[k] <= r_qb[k-1];
            end
        end
    end

    logic signed [POS_W-1:0] w_sa;
    logic signed [POS_W-1:0] w_ca;
    logic signed [POS_W-1:0] w_sb;
    logic signed [POS_W-1:0] w_cb;

    function automatic logic signed [POS_W-1:0] f_pos(input logic [SINE_W-1:0] v);
        return $signed({1'b0, v});
    endfunction

    always_comb begin
        unique case (r_qa[SINE_STAGES])
            2'd0: begin w_sa = f_pos(w_pfa);  w_ca = f_pos(w_pga);  end
            2'd1: begin w_sa = f_pos(w_pga);  w_ca = -f_pos(w_pfa); end
            2'd2: begin w_sa = -f_pos(w_pfa); w_ca = -f_pos(w_pga); end
            default: begin w_sa = -f_pos(w_pga); w_ca = f_pos(w_pfa); end
        endcase
        unique case (r_qb[SINE_STAGES])
            2'd0: begin w_sb = f_pos(w_pfb);  w_cb = f_pos(w_pgb);  end
            2'd1: begin w_sb = f_pos(w_pgb);  w_cb = -f_pos(w_pfb); end
            2'd2: begin w_sb = -f_pos(w_pfb); w_cb = -f_pos(w_pgb); end
            default: begin w_sb = -f_pos(w_pgb); w_cb = f_pos(w_pfb); end
        endcase
    end

    logic signed [34:0]      r_ring;
    logic signed [33:0]      r_zf [S_RING:S_MUL];
    logic signed [POS_W-1:0] r_ca;
    logic signed [POS_W-1:0] r_sa;
    logic signed [33:0]      w_rc;
    logic signed [33:0]      w_rs;

    assign w_rc = 34'($signed({1'b0, r_minor_radius}) * w_cb);
    assign w_rs = 34'($signed({1'b0, r_minor_radius}) * w_sb);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ring       <= $signed({3'b0, r_major_radius, 16'b0}) + 35'(w_rc);
            r_zf[S_RING] <= w_rs;
            r_ca         <= w_ca;
            r_sa         <= w_sa;
            r_zf[S_MUL]  <= r_zf[S_RING];
        end
    end

    logic signed [52:0] r_xf;
    logic signed [52:0] r_yf;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xf <= 53'(r_ring * r_ca);
            r_yf <= 53'(r_ring * r_sa);
        end
    end

    function automatic logic [POS_W-1:0] f_sat(input logic signed [20:0] v);
        if (v > 21'sd131071) begin
            return 18'h1FFFF;
        end else if (v < -21'sd131072) begin
            return 18'h20000;
        end
        return v[POS_W-1:0];
    endfunction

    logic signed [20:0] w_xs;
    logic signed [20:0] w_ys;
    logic signed [20:0] w_zs;

    assign w_xs = 21'(r_xf >>> 32);
    assign w_ys = 21'(r_yf >>> 32);
    assign w_zs = 21'(r_zf[S_MUL] >>> 16);

    logic [OUT_DATA_W-1:0] r_data;
    logic                  r_user;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_user <= r_err[S_MUL];
            if (r_err[S_MUL]) begin
                r_data <= '0;
            end else begin
                r_data <= {2'b0, r_vni[S_MUL], r_vnj[S_MUL], r_vn[S_MUL],
                           f_sat(w_zs), f_sat(w_ys), f_sat(w_xs)};
            end
        end
    end

    assign o_m_tvalid = r_vld[S_OUT];
    assign o_m_tdata  = r_data;
    assign o_m_tuser  = r_user;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == '0)
        else $error("flagged result carries data");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && !i_m_tready)
        else $error("input stalled without output back-pressure");

    a_z_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |->
            $signed(o_m_tdata[53:36]) >= -18'sd65535 && $signed(o_m_tdata[53:36]) <= 18'sd65535)
        else $error("z coordinate beyond tube radius range");

endmodule
